// ----- src/gidx_pkg.sv -----
// ---------------------------------------------------------------------------
// gidx_pkg
// Shared codes for the grid index converter: register indexes of the
// configuration port and the function select of an input beat.
// ---------------------------------------------------------------------------
package gidx_pkg;

   localparam int CSR_INDEX_BITS = 2;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_SIZE_X = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SIZE_Y = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SIZE_Z = 2'd2;

   localparam logic FUNC_TO_LINEAR = 1'b0;
   localparam logic FUNC_TO_COORD  = 1'b1;

endpackage

// ----- src/grid_index_ijk_converter_unit.sv -----
// ---------------------------------------------------------------------------
// grid_index_ijk_converter_unit
// Converts between (i, j, k) cell coordinates and the row-major linear cell
// index of a grid whose dimensions sit in configuration registers.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_stall  func, coord_i/j/k, linear_in
//   rsp_      out        rsp_valid / rsp_stall  linear_out, out_i/j/k, out_of_range
//   csr_      in         csr_valid / csr_ready  index, data (size_x/y/z)
//
// One beat is taken per cycle while req_stall is low. Two restoring dividers
// retire one quotient bit per stage: 3*DIM_BITS stages for index /
// (size_x*size_y), then DIM_BITS stages for the remainder / size_x. Reset
// clears all valid bits and the size registers. A stage holds while the
// stage after it is full and held, so bubbles close up under rsp_stall.
// csr_ready is high only while no beat is in flight.
// ---------------------------------------------------------------------------
module grid_index_ijk_converter_unit #(
   parameter int DIM_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,

   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_func,
   input  logic [DIM_BITS-1:0]                  req_coord_i,
   input  logic [DIM_BITS-1:0]                  req_coord_j,
   input  logic [DIM_BITS-1:0]                  req_coord_k,
   input  logic [3*DIM_BITS-1:0]                req_linear_in,

   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [3*DIM_BITS-1:0]                rsp_linear_out,
   output logic [DIM_BITS-1:0]                  rsp_out_i,
   output logic [DIM_BITS-1:0]                  rsp_out_j,
   output logic [DIM_BITS-1:0]                  rsp_out_k,
   output logic                                 rsp_out_of_range,

   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [gidx_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [DIM_BITS-1:0]                  csr_data
);

   localparam int LIN_BITS   = 3 * DIM_BITS;
   localparam int PLANE_BITS = 2 * DIM_BITS;
   localparam int DIV1_STEPS = LIN_BITS;
   localparam int DIV2_STEPS = DIM_BITS;
   localparam int DIV1_FIRST = 3;
   localparam int DIV2_FIRST = DIV1_FIRST + DIV1_STEPS + 1;
   localparam int OUT_STAGE  = DIV2_FIRST + DIV2_STEPS + 1;
   localparam int NUM_STAGES = OUT_STAGE + 1;

   typedef struct packed {
      logic                  func;
      logic [DIM_BITS-1:0]   ci;
      logic [DIM_BITS-1:0]   cj;
      logic [DIM_BITS-1:0]   ck;
      logic [LIN_BITS-1:0]   lin;
   } s0_type;

   typedef struct packed {
      logic                  func;
      logic [DIM_BITS-1:0]   ci;
      logic [DIM_BITS-1:0]   ck;
      logic [LIN_BITS-1:0]   lin;
      logic [PLANE_BITS-1:0] pj;
      logic [PLANE_BITS-1:0] pl;
      logic                  f0;
   } s1_type;

   typedef struct packed {
      logic                  func;
      logic [DIM_BITS-1:0]   ci;
      logic [PLANE_BITS-1:0] pj;
      logic [LIN_BITS-1:0]   pk;
      logic [LIN_BITS-1:0]   vol;
      logic [LIN_BITS-1:0]   lin;
      logic                  f0;
      logic                  zero;
   } s2_type;

   typedef struct packed {
      logic                  func;
      logic                  flag;
      logic                  zero;
      logic [LIN_BITS-1:0]   lin_out;
      logic [PLANE_BITS-1:0] rem;
      logic [LIN_BITS-1:0]   dq;
   } div1_type;

   typedef struct packed {
      logic                  func;
      logic                  flag;
      logic                  zero;
      logic [LIN_BITS-1:0]   lin_out;
      logic [DIM_BITS-1:0]   k;
      logic [DIM_BITS-1:0]   rem;
      logic [DIM_BITS-1:0]   dq;
   } div2_type;

   // Configuration.
   logic [DIM_BITS-1:0]   size_x_ff;
   logic [DIM_BITS-1:0]   size_y_ff;
   logic [DIM_BITS-1:0]   size_z_ff;
   logic [PLANE_BITS-1:0] plane_ff;

   // Pipeline control.
   logic [NUM_STAGES-1:0] vld_ff;
   logic [NUM_STAGES-1:0] vld_in;
   logic [NUM_STAGES-1:0] vld_up;
   logic [NUM_STAGES:0]   free_w;

   // Pipeline payload.
   s0_type   s0_ff;
   s1_type   s1_ff;
   s2_type   s2_ff;
   div1_type d1_ff [0:DIV1_STEPS];
   div2_type d2_ff [0:DIV2_STEPS];
   div1_type d1_first_in;
   div2_type d2_first_in;

   logic [LIN_BITS-1:0] rsp_linear_out_ff;
   logic [DIM_BITS-1:0] rsp_out_i_ff;
   logic [DIM_BITS-1:0] rsp_out_j_ff;
   logic [DIM_BITS-1:0] rsp_out_k_ff;
   logic                rsp_out_of_range_ff;

   // ------------------------------------------------------------------
   // Configuration registers. The plane size is kept as a registered
   // product for the divider stages, which an item reaches long after
   // any write.
   // ------------------------------------------------------------------
   assign csr_ready = ~(|vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= '0;
         size_y_ff <= '0;
         size_z_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            gidx_pkg::CSR_SIZE_X: size_x_ff <= csr_data;
            gidx_pkg::CSR_SIZE_Y: size_y_ff <= csr_data;
            gidx_pkg::CSR_SIZE_Z: size_z_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      plane_ff <= PLANE_BITS'(size_x_ff) * PLANE_BITS'(size_y_ff);
   end

   // ------------------------------------------------------------------
   // Stage control: a stage loads when it is empty or its beat moves on.
   // ------------------------------------------------------------------
   assign free_w[NUM_STAGES] = ~rsp_stall;

   for (genvar s = 0; s < NUM_STAGES; s++) begin : g_free
      assign free_w[s] = ~vld_ff[s] | free_w[s+1];
   end

   assign vld_up = {vld_ff[NUM_STAGES-2:0], req_valid};
   assign vld_in = (free_w[NUM_STAGES-1:0] & vld_up) | (~free_w[NUM_STAGES-1:0] & vld_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_stall = ~free_w[0];

   // ------------------------------------------------------------------
   // Front: capture, products, sum and range checks.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (free_w[0]) begin
         s0_ff.func <= req_func;
         s0_ff.ci   <= req_coord_i;
         s0_ff.cj   <= req_coord_j;
         s0_ff.ck   <= req_coord_k;
         s0_ff.lin  <= req_linear_in;
      end
   end

   always_ff @(posedge clock) begin
      if (free_w[1]) begin
         s1_ff.func <= s0_ff.func;
         s1_ff.ci   <= s0_ff.ci;
         s1_ff.ck   <= s0_ff.ck;
         s1_ff.lin  <= s0_ff.lin;
         s1_ff.pj   <= PLANE_BITS'(s0_ff.cj) * PLANE_BITS'(size_x_ff);
         s1_ff.pl   <= PLANE_BITS'(size_x_ff) * PLANE_BITS'(size_y_ff);
         s1_ff.f0   <= (s0_ff.ci >= size_x_ff) || (s0_ff.cj >= size_y_ff) ||
                       (s0_ff.ck >= size_z_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (free_w[2]) begin
         s2_ff.func <= s1_ff.func;
         s2_ff.ci   <= s1_ff.ci;
         s2_ff.pj   <= s1_ff.pj;
         s2_ff.pk   <= LIN_BITS'(s1_ff.ck) * LIN_BITS'(s1_ff.pl);
         s2_ff.vol  <= LIN_BITS'(s1_ff.pl) * LIN_BITS'(size_z_ff);
         s2_ff.lin  <= s1_ff.lin;
         s2_ff.f0   <= s1_ff.f0;
         s2_ff.zero <= (s1_ff.pl == '0);
      end
   end

   // An empty plane gives a zero volume, so the index compare raises the
   // flag on its own in that case.
   always_comb begin
      d1_first_in.func    = s2_ff.func;
      d1_first_in.flag    = (s2_ff.func == gidx_pkg::FUNC_TO_COORD) ?
                            (s2_ff.lin >= s2_ff.vol) : s2_ff.f0;
      d1_first_in.zero    = s2_ff.zero;
      d1_first_in.lin_out = LIN_BITS'(s2_ff.ci) + LIN_BITS'(s2_ff.pj) + s2_ff.pk;
      d1_first_in.rem     = '0;
      d1_first_in.dq      = s2_ff.lin;
   end

   always_ff @(posedge clock) begin
      if (free_w[DIV1_FIRST]) begin
         d1_ff[0] <= d1_first_in;
      end
   end

   // ------------------------------------------------------------------
   // Index / plane, one quotient bit per stage.
   // ------------------------------------------------------------------
   for (genvar t = 0; t < DIV1_STEPS; t++) begin : g_div1
      logic [PLANE_BITS-1:0] rem_in;
      logic [LIN_BITS-1:0]   dq_in;

      gidx_div_step #(
         .REM_BITS (PLANE_BITS),
         .DQ_BITS  (LIN_BITS)
      ) u_step (
         .divisor (plane_ff),
         .rem_i   (d1_ff[t].rem),
         .dq_i    (d1_ff[t].dq),
         .rem_o   (rem_in),
         .dq_o    (dq_in)
      );

      always_ff @(posedge clock) begin
         if (free_w[DIV1_FIRST+t+1]) begin
            d1_ff[t+1].func    <= d1_ff[t].func;
            d1_ff[t+1].flag    <= d1_ff[t].flag;
            d1_ff[t+1].zero    <= d1_ff[t].zero;
            d1_ff[t+1].lin_out <= d1_ff[t].lin_out;
            d1_ff[t+1].rem     <= rem_in;
            d1_ff[t+1].dq      <= dq_in;
         end
      end
   end

   // The remainder is below size_x*size_y, so its upper half is already
   // below size_x and only DIM_BITS quotient bits remain for j.
   always_comb begin
      d2_first_in.func    = d1_ff[DIV1_STEPS].func;
      d2_first_in.flag    = d1_ff[DIV1_STEPS].flag;
      d2_first_in.zero    = d1_ff[DIV1_STEPS].zero;
      d2_first_in.lin_out = d1_ff[DIV1_STEPS].lin_out;
      d2_first_in.k       = (|d1_ff[DIV1_STEPS].dq[LIN_BITS-1:DIM_BITS]) ? '1 :
                            d1_ff[DIV1_STEPS].dq[DIM_BITS-1:0];
      d2_first_in.rem     = d1_ff[DIV1_STEPS].rem[PLANE_BITS-1:DIM_BITS];
      d2_first_in.dq      = d1_ff[DIV1_STEPS].rem[DIM_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (free_w[DIV2_FIRST]) begin
         d2_ff[0] <= d2_first_in;
      end
   end

   // ------------------------------------------------------------------
   // Remainder / size_x, one quotient bit per stage.
   // ------------------------------------------------------------------
   for (genvar u = 0; u < DIV2_STEPS; u++) begin : g_div2
      logic [DIM_BITS-1:0] rem_in;
      logic [DIM_BITS-1:0] dq_in;

      gidx_div_step #(
         .REM_BITS (DIM_BITS),
         .DQ_BITS  (DIM_BITS)
      ) u_step (
         .divisor (size_x_ff),
         .rem_i   (d2_ff[u].rem),
         .dq_i    (d2_ff[u].dq),
         .rem_o   (rem_in),
         .dq_o    (dq_in)
      );

      always_ff @(posedge clock) begin
         if (free_w[DIV2_FIRST+u+1]) begin
            d2_ff[u+1].func    <= d2_ff[u].func;
            d2_ff[u+1].flag    <= d2_ff[u].flag;
            d2_ff[u+1].zero    <= d2_ff[u].zero;
            d2_ff[u+1].lin_out <= d2_ff[u].lin_out;
            d2_ff[u+1].k       <= d2_ff[u].k;
            d2_ff[u+1].rem     <= rem_in;
            d2_ff[u+1].dq      <= dq_in;
         end
      end
   end

   // ------------------------------------------------------------------
   // Output register.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (free_w[OUT_STAGE]) begin
         rsp_out_of_range_ff <= d2_ff[DIV2_STEPS].flag;
         if (d2_ff[DIV2_STEPS].func == gidx_pkg::FUNC_TO_LINEAR) begin
            rsp_linear_out_ff <= d2_ff[DIV2_STEPS].lin_out;
            rsp_out_i_ff      <= '0;
            rsp_out_j_ff      <= '0;
            rsp_out_k_ff      <= '0;
         end else if (d2_ff[DIV2_STEPS].zero) begin
            rsp_linear_out_ff <= '0;
            rsp_out_i_ff      <= '0;
            rsp_out_j_ff      <= '0;
            rsp_out_k_ff      <= '0;
         end else begin
            rsp_linear_out_ff <= '0;
            rsp_out_i_ff      <= d2_ff[DIV2_STEPS].rem;
            rsp_out_j_ff      <= d2_ff[DIV2_STEPS].dq;
            rsp_out_k_ff      <= d2_ff[DIV2_STEPS].k;
         end
      end
   end

   assign rsp_valid        = vld_ff[OUT_STAGE];
   assign rsp_linear_out   = rsp_linear_out_ff;
   assign rsp_out_i        = rsp_out_i_ff;
   assign rsp_out_j        = rsp_out_j_ff;
   assign rsp_out_k        = rsp_out_k_ff;
   assign rsp_out_of_range = rsp_out_of_range_ff;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------

   // The input is held back only when every stage is full and the output
   // beat is not being taken.
   a_stall_only_when_full: assert property (
      @(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall && (&vld_ff))
   ) else $error("input stalled while the pipeline has room");

   // A beat inside the grid gives coordinates inside the grid.
   a_coords_in_grid: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_out_of_range) |->
         ((rsp_out_i < size_x_ff) && (rsp_out_j < size_y_ff) && (rsp_out_k < size_z_ff))
   ) else $error("in-range result with coordinates outside the grid");

   // An empty plane always flags and never yields coordinates.
   a_zero_plane: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && ((size_x_ff == '0) || (size_y_ff == '0))) |->
         (rsp_out_of_range && (rsp_out_i == '0) && (rsp_out_j == '0) && (rsp_out_k == '0))
   ) else $error("empty plane result not flagged or not cleared");

   // The two result kinds never mix in one beat.
   a_one_kind: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_linear_out != '0)) |->
         ((rsp_out_i == '0) && (rsp_out_j == '0) && (rsp_out_k == '0))
   ) else $error("linear index and coordinates both nonzero");

   // Configuration only changes with nothing in flight.
   a_csr_when_empty: assert property (
      @(posedge clock) disable iff (reset)
      (csr_valid && csr_ready) |=> (vld_ff[NUM_STAGES-1:1] == '0)
   ) else $error("configuration written while beats were in flight");

endmodule

// ----- src/gidx_div_step.sv -----
// ---------------------------------------------------------------------------
// gidx_div_step
// One step of a restoring divider. The partial remainder takes the next
// dividend bit from the top of dq_i; the quotient bit enters at the bottom.
// ---------------------------------------------------------------------------
module gidx_div_step #(
   parameter int REM_BITS = 32,
   parameter int DQ_BITS  = 48
) (
   input  logic [REM_BITS-1:0] divisor,
   input  logic [REM_BITS-1:0] rem_i,
   input  logic [DQ_BITS-1:0]  dq_i,
   output logic [REM_BITS-1:0] rem_o,
   output logic [DQ_BITS-1:0]  dq_o
);

   logic [REM_BITS:0]   trial;
   logic [REM_BITS+1:0] diff;
   logic                fits;

   assign trial = {rem_i, dq_i[DQ_BITS-1]};
   // One spare bit on top so the borrow shows whether the divisor fits.
   assign diff  = {1'b0, trial} - {2'b00, divisor};
   assign fits  = ~diff[REM_BITS+1];

   assign rem_o = fits ? diff[REM_BITS-1:0] : trial[REM_BITS-1:0];
   assign dq_o  = {dq_i[DQ_BITS-2:0], fits};

endmodule
